>>> src/tms_pkg.sv
// shared types, command and status codes for the transform matrix stack
package tms_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned LVL_W  = 5;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [2:0] {
    CMD_STAGE   = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_PUSH_ID = 3'd2,
    CMD_POP     = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ZERO_LEN  = 3'd4
  } status_e;

  localparam elem_t ELEM_MAX = 32'sh7fff_ffff;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;
  localparam acc_t  ACC_MAX  = acc_t'(ELEM_MAX);
  localparam acc_t  ACC_MIN  = acc_t'(ELEM_MIN);

  localparam logic [3:0] ELEM_LAST = 4'd15;
  localparam logic [3:0] DIV_LAST  = 4'd10;
  localparam logic [1:0] DIV_COL_END = 2'd2;
  localparam logic [1:0] K_LAST    = 2'd3;
  localparam logic [1:0] SQ_K_LAST = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        which_stack;
    elem_t       value;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LVL_W-1:0] level;
    elem_t            read_value;
  } out_t;

  typedef struct packed {
    logic       cap_in;
    logic       stage_wr;
    logic       lvl_inc;
    logic       lvl_dec;
    logic       top_rd;
    logic       nrm_init;
    logic       nrm_ident;
    logic       mul_en;
    logic       mul_sq;
    logic       acc_load;
    logic       acc_add;
    logic       sqrt_start;
    logic       div_start;
    logic       div_wr;
    logic       copy_wr;
    logic       mm_rd;
    logic       mm_wr;
    logic       out_load;
    logic       rd_en;
    status_e    status;
    logic [3:0] elem;
    logic [1:0] k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       lvl_zero;
    logic       lvl_full;
    logic       len_zero;
    logic       sqrt_done;
    logic       div_done;
  } ctrl_stat_t;

endpackage

>>> src/transform_matrix_stack_unit.sv
// top level of the transform matrix stack
//
// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o    in_i  (tms_pkg::in_t)
// out       output     out_valid_o / out_ready_i  out_o (tms_pkg::out_t)
//
// stage, pop, read and unused commands go from decode straight to the response state
// a push at level 0 copies the staging matrix into the new entry; a push onto a previous top
// multiplies the top by it in 64 read, multiply and accumulate steps per stack on one memory port
// a plain push also adds 3 squares, a square root and 9 divides
// the next item is taken once the result has left; out_ready_i low holds the block
// reset clears the staging matrix and level; stack entries are valid once pushed
module transform_matrix_stack_unit #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tms_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tms_pkg::out_t out_o
);

  tms_pkg::ctrl_cmd_t  cmd;
  tms_pkg::ctrl_stat_t stat;

  tms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tms_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

>>> src/tms_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module tms_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tms_pkg::SQ_W-1:0]     x_i,
  output logic [tms_pkg::LEN_W-1:0]    root_o,
  output logic                         done_o
);

  logic [tms_pkg::SQ_W-1:0]  x_q;
  logic [34:0]               rem_q, rem_d;
  logic [tms_pkg::LEN_W-1:0] root_q, root_d;
  logic [4:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [36:0]               rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, x_q[tms_pkg::SQ_W-1 -: 2]};
    trial  = 37'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = 35'(rem_sh - trial);
      root_d = {root_q[tms_pkg::LEN_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[34:0];
      root_d = {root_q[tms_pkg::LEN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[tms_pkg::SQ_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> src/tms_div.sv
// restoring unsigned divider, one quotient bit per cycle
module tms_div #(
  parameter int unsigned DW = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [tms_pkg::LEN_W-1:0] divisor_i,
  output logic [DW-1:0]             quotient_o,
  output logic                      done_o
);

  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0]             dvd_q;
  logic [tms_pkg::LEN_W-1:0] dsr_q;
  logic [tms_pkg::LEN_W-1:0] rem_q, rem_d;
  logic [tms_pkg::LEN_W:0]   rem_sh;
  logic                      ge;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_d  = ge ? tms_pkg::LEN_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[tms_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(DW-1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW-1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dvd_q;
  assign done_o     = done_q;

endmodule

>>> src/tms_dp.sv
// datapath: staging matrix, stack memories, multiply-accumulate lanes, sqrt and divide
module tms_dp #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tms_pkg::in_t        in_i,
  input  tms_pkg::ctrl_cmd_t  cmd_i,
  output tms_pkg::ctrl_stat_t stat_o,
  output tms_pkg::out_t       out_o
);

  localparam int unsigned SW    = $clog2(STACK_DEPTH);
  localparam int unsigned LW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = SW + 4;
  localparam int unsigned MEM_D = STACK_DEPTH * 16;
  localparam int unsigned DW    = tms_pkg::ELEM_W + FRAC_BITS;

  localparam tms_pkg::elem_t ONE_FIX  = 32'sd1 <<< FRAC_BITS;
  localparam tms_pkg::acc_t  ACC_HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic [DW-1:0]  NEG_LIM  = DW'(33'h0_8000_0000);
  localparam logic [DW-1:0]  POS_LIM  = DW'(32'h7fff_ffff);

  tms_pkg::in_t   in_q;
  tms_pkg::elem_t stage_q [16];
  tms_pkg::elem_t nrm_q   [16];
  logic [LW-1:0]  level_q;
  tms_pkg::elem_t img_mem [MEM_D];
  tms_pkg::elem_t nrm_mem [MEM_D];
  tms_pkg::elem_t img_rd_q, nrm_rd_q;
  tms_pkg::prod_t img_prod_q, nrm_prod_q;
  tms_pkg::acc_t  img_acc_q, nrm_acc_q;
  tms_pkg::out_t  out_q;

  logic [SW-1:0]  top_idx, wr_idx;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [3:0]     bidx, sq_idx;
  tms_pkg::elem_t img_a, img_b;
  tms_pkg::elem_t img_wdata, nrm_wdata;
  logic [tms_pkg::LEN_W-1:0] len;
  logic           sqrt_done, div_done;
  tms_pkg::elem_t div_e;
  logic [31:0]    div_mag;
  logic [DW-1:0]  dvd, quo;
  tms_pkg::elem_t quo_sat;

  function automatic tms_pkg::elem_t round_sat(tms_pkg::acc_t a);
    tms_pkg::acc_t s;
    s = (a + ACC_HALF) >>> FRAC_BITS;
    if (s > tms_pkg::ACC_MAX) begin
      return tms_pkg::ELEM_MAX;
    end else if (s < tms_pkg::ACC_MIN) begin
      return tms_pkg::ELEM_MIN;
    end
    return s[tms_pkg::ELEM_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 16; e++) begin
        stage_q[e] <= '0;
      end
    end else if (cmd_i.stage_wr) begin
      stage_q[{in_q.row, in_q.col}] <= in_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (cmd_i.lvl_inc) begin
      level_q <= level_q + LW'(1);
    end else if (cmd_i.lvl_dec) begin
      level_q <= level_q - LW'(1);
    end
  end

  // normal operand: staged matrix without translation, then scaled 3x3, or identity for push_id
  always_ff @(posedge clk_i) begin
    if (cmd_i.nrm_init) begin
      for (int e = 0; e < 16; e++) begin
        nrm_q[e] <= (e == 3 || e == 7 || e == 11) ? '0 : stage_q[e];
      end
    end else if (cmd_i.nrm_ident) begin
      for (int e = 0; e < 16; e++) begin
        nrm_q[e] <= (e == 0 || e == 5 || e == 10 || e == 15) ? ONE_FIX : '0;
      end
    end else if (cmd_i.div_wr) begin
      nrm_q[cmd_i.elem] <= quo_sat;
    end
  end

  assign top_idx = SW'(level_q - LW'(1));
  assign wr_idx  = level_q[SW-1:0];
  assign rd_addr = cmd_i.top_rd ? {top_idx, in_q.row, in_q.col}
                                : {top_idx, cmd_i.elem[3:2], cmd_i.k};
  assign wr_addr = {wr_idx, cmd_i.elem};

  assign img_wdata = cmd_i.copy_wr ? stage_q[cmd_i.elem] : round_sat(img_acc_q);
  assign nrm_wdata = cmd_i.copy_wr ? nrm_q[cmd_i.elem]   : round_sat(nrm_acc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr || cmd_i.mm_wr) begin
      img_mem[wr_addr] <= img_wdata;
      nrm_mem[wr_addr] <= nrm_wdata;
    end
    if (cmd_i.top_rd || cmd_i.mm_rd) begin
      img_rd_q <= img_mem[rd_addr];
      nrm_rd_q <= nrm_mem[rd_addr];
    end
  end

  assign bidx   = {cmd_i.k, cmd_i.elem[1:0]};
  assign sq_idx = {2'b00, cmd_i.k};
  assign img_a  = cmd_i.mul_sq ? stage_q[sq_idx] : img_rd_q;
  assign img_b  = cmd_i.mul_sq ? stage_q[sq_idx] : stage_q[bidx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      img_prod_q <= img_a * img_b;
      nrm_prod_q <= nrm_rd_q * nrm_q[bidx];
    end
    if (cmd_i.acc_load) begin
      img_acc_q <= tms_pkg::acc_t'(img_prod_q);
      nrm_acc_q <= tms_pkg::acc_t'(nrm_prod_q);
    end else if (cmd_i.acc_add) begin
      img_acc_q <= img_acc_q + tms_pkg::acc_t'(img_prod_q);
      nrm_acc_q <= nrm_acc_q + tms_pkg::acc_t'(nrm_prod_q);
    end
  end

  tms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .x_i     (img_acc_q[tms_pkg::SQ_W-1:0]),
    .root_o  (len),
    .done_o  (sqrt_done)
  );

  assign div_e   = stage_q[cmd_i.elem];
  assign div_mag = div_e[31] ? 32'(32'd0 - div_e) : 32'(div_e);
  assign dvd     = (DW'(div_mag) << FRAC_BITS) + DW'(len[tms_pkg::LEN_W-1:1]);

  tms_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (len),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    if (div_e[31]) begin
      quo_sat = (quo > NEG_LIM) ? tms_pkg::ELEM_MIN
                                : tms_pkg::elem_t'(32'd0 - quo[31:0]);
    end else begin
      quo_sat = (quo > POS_LIM) ? tms_pkg::ELEM_MAX : tms_pkg::elem_t'(quo[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status     <= cmd_i.status;
      out_q.level      <= tms_pkg::LVL_W'(level_q);
      out_q.read_value <= cmd_i.rd_en ? (in_q.which_stack ? nrm_rd_q : img_rd_q) : '0;
    end
  end

  assign stat_o.command   = in_q.command;
  assign stat_o.lvl_zero  = (level_q == '0);
  assign stat_o.lvl_full  = (level_q >= LW'(STACK_DEPTH));
  assign stat_o.len_zero  = (len == '0);
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.div_done  = div_done;
  assign out_o            = out_q;

endmodule

>>> src/tms_ctrl.sv
// controller: command decode and push sequencing
module tms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tms_pkg::ctrl_stat_t stat_i,
  output tms_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DECODE   = 15'b000000000000010,
    S_SQ_MUL   = 15'b000000000000100,
    S_SQ_ACC   = 15'b000000000001000,
    S_SQ_GO    = 15'b000000000010000,
    S_SQ_WAIT  = 15'b000000000100000,
    S_DIV_GO   = 15'b000000001000000,
    S_DIV_WAIT = 15'b000000010000000,
    S_COPY     = 15'b000000100000000,
    S_MM_RD    = 15'b000001000000000,
    S_MM_MUL   = 15'b000010000000000,
    S_MM_ACC   = 15'b000100000000000,
    S_MM_WR    = 15'b001000000000000,
    S_RESP     = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        elem_q, elem_d;
  logic [1:0]        k_q, k_d;
  tms_pkg::status_e  status_q, status_d;
  logic              rd_en_q, rd_en_d;
  state_e            push_next;

  assign push_next = stat_i.lvl_zero ? S_COPY : S_MM_RD;

  always_comb begin
    state_d  = state_q;
    elem_d   = elem_q;
    k_d      = k_q;
    status_d = status_q;
    rd_en_d  = rd_en_q;
    cmd_o        = '0;
    cmd_o.elem   = elem_q;
    cmd_o.k      = k_q;
    cmd_o.status = status_q;
    cmd_o.rd_en  = rd_en_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = tms_pkg::ST_OK;
        rd_en_d  = 1'b0;
        elem_d   = '0;
        k_d      = '0;
        state_d  = S_RESP;
        unique case (stat_i.command) inside
          tms_pkg::CMD_STAGE: begin
            cmd_o.stage_wr = 1'b1;
          end
          tms_pkg::CMD_PUSH, tms_pkg::CMD_PUSH_ID: begin
            if (stat_i.lvl_full) begin
              status_d = tms_pkg::ST_OVERFLOW;
            end else if (stat_i.command == tms_pkg::CMD_PUSH) begin
              cmd_o.nrm_init = 1'b1;
              state_d        = S_SQ_MUL;
            end else begin
              cmd_o.nrm_ident = 1'b1;
              state_d         = push_next;
            end
          end
          tms_pkg::CMD_POP: begin
            if (stat_i.lvl_zero) begin
              status_d = tms_pkg::ST_UNDERFLOW;
            end else begin
              cmd_o.lvl_dec = 1'b1;
            end
          end
          tms_pkg::CMD_READ: begin
            if (stat_i.lvl_zero) begin
              status_d = tms_pkg::ST_EMPTY;
            end else begin
              cmd_o.top_rd = 1'b1;
              rd_en_d      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_SQ_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sq = 1'b1;
        state_d      = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.acc_load = (k_q == '0);
        cmd_o.acc_add  = (k_q != '0);
        if (k_q == tms_pkg::SQ_K_LAST) begin
          k_d     = '0;
          state_d = S_SQ_GO;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_SQ_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (stat_i.sqrt_done) begin
          if (stat_i.len_zero) begin
            status_d = tms_pkg::ST_ZERO_LEN;
            state_d  = S_RESP;
          end else begin
            elem_d  = '0;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          if (elem_q == tms_pkg::DIV_LAST) begin
            elem_d  = '0;
            state_d = push_next;
          end else begin
            elem_d  = elem_q + ((elem_q[1:0] == tms_pkg::DIV_COL_END) ? 4'd2 : 4'd1);
            state_d = S_DIV_GO;
          end
        end
      end
      S_COPY: begin
        cmd_o.copy_wr = 1'b1;
        if (elem_q == tms_pkg::ELEM_LAST) begin
          cmd_o.lvl_inc = 1'b1;
          state_d       = S_RESP;
        end else begin
          elem_d = elem_q + 4'd1;
        end
      end
      S_MM_RD: begin
        cmd_o.mm_rd = 1'b1;
        state_d     = S_MM_MUL;
      end
      S_MM_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MM_ACC;
      end
      S_MM_ACC: begin
        cmd_o.acc_load = (k_q == '0);
        cmd_o.acc_add  = (k_q != '0);
        if (k_q == tms_pkg::K_LAST) begin
          state_d = S_MM_WR;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_MM_RD;
        end
      end
      S_MM_WR: begin
        cmd_o.mm_wr = 1'b1;
        k_d         = '0;
        if (elem_q == tms_pkg::ELEM_LAST) begin
          cmd_o.lvl_inc = 1'b1;
          state_d       = S_RESP;
        end else begin
          elem_d  = elem_q + 4'd1;
          state_d = S_MM_RD;
        end
      end
      S_RESP: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      elem_q   <= '0;
      k_q      <= '0;
      status_q <= tms_pkg::ST_OK;
      rd_en_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      elem_q   <= elem_d;
      k_q      <= k_d;
      status_q <= status_d;
      rd_en_q  <= rd_en_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule
